/* hdl/jcs_pkg.sv */
// Package with the scan modes, character codes and the per-byte scan function of the stripper.
`default_nettype none

package jcs_pkg;

  typedef enum logic [2:0] {
    MODE_GLOBAL = 3'd0,
    MODE_LINE   = 3'd1,
    MODE_BLOCK  = 3'd2,
    MODE_SQ     = 3'd3,
    MODE_DQ     = 3'd4
  } mode_t;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_PATCH = 1'b1;

  // Outcome of scanning one byte.
  typedef struct packed {
    mode_t      mode;
    logic       comma_seen;
    logic       set_pos;
    logic [7:0] emit;
    logic       patch;
    logic       blank_la;
  } scan_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic scan_t jcs_scan(input mode_t mode, input logic comma_seen,
                                     input logic [7:0] raw, input logic blanked,
                                     input logic [7:0] la, input logic la_ok);
    logic [7:0] c;
    scan_t r;
    c = blanked ? CH_SPACE : raw;
    r.mode = mode;
    r.comma_seen = comma_seen;
    r.set_pos = 1'b0;
    r.emit = c;
    r.patch = 1'b0;
    r.blank_la = 1'b0;
    case (mode)
      MODE_LINE: begin
        if (c == CH_NL) r.mode = MODE_GLOBAL;
        else r.emit = CH_SPACE;
      end
      MODE_BLOCK: begin
        if (c == CH_STAR && la_ok && la == CH_SLASH) begin
          r.blank_la = 1'b1;
          r.mode = MODE_GLOBAL;
        end
        r.emit = CH_SPACE;
      end
      MODE_SQ: begin
        if (c == CH_SQUOTE) r.mode = MODE_GLOBAL;
        r.comma_seen = 1'b0;
      end
      MODE_DQ: begin
        if (c == CH_DQUOTE) r.mode = MODE_GLOBAL;
        r.comma_seen = 1'b0;
      end
      default: begin
        r.mode = MODE_GLOBAL;
        if (c == CH_DQUOTE) begin
          r.mode = MODE_DQ;
          r.comma_seen = 1'b0;
        end else if (c == CH_SQUOTE) begin
          r.mode = MODE_SQ;
          r.comma_seen = 1'b0;
        end else if (c == CH_SLASH) begin
          if (la_ok && la == CH_SLASH) begin
            r.mode = MODE_LINE;
            r.emit = CH_SPACE;
          end else if (la_ok && la == CH_STAR) begin
            r.mode = MODE_BLOCK;
            r.emit = CH_SPACE;
            r.blank_la = 1'b1;
          end
        end else if (c == CH_RBRACK || c == CH_RBRACE) begin
          if (comma_seen) begin
            r.patch = 1'b1;
            r.comma_seen = 1'b0;
          end
        end else if (!is_ws(c)) begin
          r.comma_seen = (c == CH_COMMA);
          r.set_pos = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/json_comment_stripper_core.sv */
// Top level of the JSON comment and trailing-comma stripper.
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid, in_ready, in_byte, in_last             | request in
//   out     | out_valid, out_ready, out_kind, out_byte,        | request out
//           | out_position, out_last                           |
//
// Each accepted byte is held and scanned, with the next byte as lookahead, when that
// byte is taken; the final byte is scanned at once. The results (zero to four) go into
// a four-entry result queue that drains one result per cycle while out_ready is high.
// A patch or the end of a document adds extra results to hand over on the single port.
// A new byte is taken while the last queued result is being handed over.
// Synchronous reset empties the queue and returns the scanner to the global mode.
`default_nettype none

module json_comment_stripper_core #(
  parameter int POSITION_WIDTH = 24
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                in_byte,
  input  wire logic                      in_last,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_kind,
  output logic [7:0]                     out_byte,
  output logic [POSITION_WIDTH-1:0]      out_position,
  output logic                           out_last
);
  import jcs_pkg::*;

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

  typedef struct packed {
    logic                      kind;
    logic [7:0]                data;
    logic [POSITION_WIDTH-1:0] pos;
    logic                      last;
  } result_t;

  // Scanner state.
  mode_t                     scan_mode, scan_mode_next;
  logic [7:0]                held_byte;
  logic                      held_valid, held_valid_next;
  logic                      blank_held, blank_held_next;
  logic [POSITION_WIDTH-1:0] byte_counter, byte_counter_next;
  logic                      comma_seen, comma_seen_next;
  logic [POSITION_WIDTH-1:0] comma_position, comma_position_next;

  // Result queue, entry 0 is presented on the output.
  result_t    queue [4];
  logic [2:0] count;

  result_t    fresh [4];
  logic [2:0] fresh_count;

  logic accept, pop;
  scan_t s1, s2;
  mode_t mode1;
  logic  comma1, blank_new;
  logic [POSITION_WIDTH-1:0] cpos1, cpos2, counter1;

  assign out_valid    = (count != 3'd0);
  assign pop          = out_valid && out_ready;
  assign in_ready     = (count == 3'd0) || ((count == 3'd1) && out_ready);
  assign accept       = in_valid && in_ready;
  assign out_kind     = queue[0].kind;
  assign out_byte     = queue[0].data;
  assign out_position = queue[0].pos;
  assign out_last     = queue[0].last;

  always_comb begin
    s1 = jcs_scan(scan_mode, comma_seen, held_byte, blank_held, in_byte, 1'b1);
    mode1     = held_valid ? s1.mode : scan_mode;
    comma1    = held_valid ? s1.comma_seen : comma_seen;
    cpos1     = (held_valid && s1.set_pos) ? byte_counter : comma_position;
    blank_new = held_valid && s1.blank_la;
    counter1  = (held_valid && byte_counter != POS_MAX) ?
                byte_counter + 1'b1 : byte_counter;
    // The final byte has no lookahead.
    s2 = jcs_scan(mode1, comma1, in_byte, blank_new, CH_SPACE, 1'b0);
    cpos2 = s2.set_pos ? counter1 : cpos1;

    for (int i = 0; i < 4; i++) begin
      fresh[i] = '{kind: KIND_BYTE, data: CH_SPACE, pos: '0, last: 1'b0};
    end
    fresh_count = 3'd0;
    if (held_valid) begin
      fresh[0] = '{kind: KIND_BYTE, data: s1.emit, pos: byte_counter, last: 1'b0};
      fresh_count = 3'd1;
      if (s1.patch) begin
        fresh[1] = '{kind: KIND_PATCH, data: CH_SPACE, pos: cpos1, last: 1'b0};
        fresh_count = 3'd2;
      end
    end
    if (in_last) begin
      fresh[fresh_count[1:0]] = '{kind: KIND_BYTE, data: s2.emit, pos: counter1,
                                  last: !s2.patch};
      fresh_count = fresh_count + 3'd1;
      if (s2.patch) begin
        fresh[fresh_count[1:0]] = '{kind: KIND_PATCH, data: CH_SPACE, pos: cpos2,
                                    last: 1'b1};
        fresh_count = fresh_count + 3'd1;
      end
    end
  end

  // Next state of the scanner for an accepted byte; the end of a document resets it.
  always_comb begin
    scan_mode_next      = mode1;
    held_valid_next     = 1'b1;
    blank_held_next     = blank_new;
    byte_counter_next   = counter1;
    comma_seen_next     = comma1;
    comma_position_next = cpos1;
    if (in_last) begin
      scan_mode_next      = MODE_GLOBAL;
      held_valid_next     = 1'b0;
      blank_held_next     = 1'b0;
      byte_counter_next   = '0;
      comma_seen_next     = 1'b0;
      comma_position_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= MODE_GLOBAL;
      held_byte      <= '0;
      held_valid     <= 1'b0;
      blank_held     <= 1'b0;
      byte_counter   <= '0;
      comma_seen     <= 1'b0;
      comma_position <= '0;
    end else if (accept) begin
      scan_mode      <= scan_mode_next;
      held_byte      <= in_last ? 8'h00 : in_byte;
      held_valid     <= held_valid_next;
      blank_held     <= blank_held_next;
      byte_counter   <= byte_counter_next;
      comma_seen     <= comma_seen_next;
      comma_position <= comma_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
    end else if (accept) begin
      count <= fresh_count;
    end else if (pop) begin
      count <= count - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 4; i++) queue[i] <= fresh[i];
    end else if (pop) begin
      for (int i = 0; i < 3; i++) queue[i] <= queue[i+1];
      queue[3] <= queue[3];
    end
  end

endmodule

`default_nettype wire

/* hdl/jcs_checker.sv */
// Port-level checker for the stripper and the bind that attaches it.
`default_nettype none

module jcs_checker #(
  parameter int POSITION_WIDTH = 24
) (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      in_last,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic                      out_kind,
  input wire logic [7:0]                out_byte,
  input wire logic [POSITION_WIDTH-1:0] out_position,
  input wire logic                      out_last
);
  import jcs_pkg::*;

  // A patch always carries a space.
  a_patch_space: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_PATCH) |-> (out_byte == CH_SPACE))
    else $error("patch result without a space byte");

  // The final byte of a document always yields a result in the next cycle.
  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> out_valid)
    else $error("no result after the final byte of a document");

  // With nothing waiting at the output the block takes a new byte.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output is empty");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_kind) && $stable(out_byte) &&
       $stable(out_position) && $stable(out_last)))
    else $error("result changed while stalled");

endmodule

bind json_comment_stripper_core jcs_checker #(.POSITION_WIDTH(POSITION_WIDTH)) u_jcs_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_valid), .in_ready(in_ready), .in_last(in_last),
  .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
  .out_byte(out_byte), .out_position(out_position), .out_last(out_last)
);

`default_nettype wire
